// File: hdl/sem_pkg.sv
// Shared constants and types for the RGB Sobel edge magnitude block.
`default_nettype none
package sem_pkg;
	localparam int MAX_WIDTH = 1024;
	localparam logic [10:0] FW_RST = 11'd640;
	localparam logic [15:0] FH_RST = 16'd480;
	localparam logic CFG_FRAME_WIDTH = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;
	localparam logic [7:0] MAG_MAX = 8'd255;
	typedef logic [8:0][7:0] sem_nbr_t;
	typedef logic [8:0][23:0] sem_win_t;
endpackage
`default_nettype wire

// File: hdl/sem_lbuf.sv
// Line buffer memory: upper and middle line pixels of one column per entry.
`default_nettype none
module sem_lbuf #(
	parameter int DEPTH = sem_pkg::MAX_WIDTH,
	parameter int AW = 10
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [47:0] wr_data,
	input wire logic [AW-1:0] rd_addr,
	output logic [47:0] rd_data
);
	logic [47:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// File: hdl/sem_mag.sv
// One channel: Sobel gradients, sum of squares, bit-serial integer square root.
`default_nettype none
module sem_mag (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire sem_pkg::sem_nbr_t nbr,
	output logic done,
	output logic [7:0] mag
);
	logic [3:0] ph_q;
	logic signed [11:0] gx_q, gy_q;
	logic [20:0] sq_q;
	logic [7:0] r_q;
	logic [9:0] pos_x, neg_x, pos_y, neg_y;
	logic [7:0] t;
	logic [15:0] tt;
	logic [2:0] bidx;
	logic signed [23:0] px2, py2;

	assign pos_x = 10'(nbr[2]) + {1'b0, nbr[5], 1'b0} + 10'(nbr[8]);
	assign neg_x = 10'(nbr[0]) + {1'b0, nbr[3], 1'b0} + 10'(nbr[6]);
	assign pos_y = 10'(nbr[6]) + {1'b0, nbr[7], 1'b0} + 10'(nbr[8]);
	assign neg_y = 10'(nbr[0]) + {1'b0, nbr[1], 1'b0} + 10'(nbr[2]);
	assign px2 = gx_q * gx_q;
	assign py2 = gy_q * gy_q;
	assign bidx = 3'(4'd9 - ph_q);
	assign t = r_q | (8'd1 << bidx);
	assign tt = t * t;
	assign mag = (sq_q[20:16] != 5'd0) ? sem_pkg::MAG_MAX : r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 4'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				ph_q <= 4'd1;
			end else if (ph_q == 4'd9) begin
				ph_q <= 4'd0;
				done <= 1'b1;
			end else if (ph_q != 4'd0) begin
				ph_q <= ph_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gx_q <= $signed({2'b00, pos_x}) - $signed({2'b00, neg_x});
			gy_q <= $signed({2'b00, pos_y}) - $signed({2'b00, neg_y});
		end else if (ph_q == 4'd1) begin
			sq_q <= 21'(px2) + 21'(py2);
			r_q <= 8'd0;
		end else if (ph_q >= 4'd2) begin
			if (tt <= sq_q[15:0]) begin
				r_q <= t;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/sobel_edge_magnitude_rgb.sv
// A pixel item with a result first updates the window, then each result takes the gradients,
// the squares, 8 root steps and an output load.
// A drain item loads three columns, then computes its result the same way.
// One item at a time: a pixel gives no result, one or two; a new item is accepted only after its
// last result is loaded, and a finished result waits while the previous one has not left.
// Reset (arst_n low, asynchronous) restores width 640, height 480 and a fresh frame.
`default_nettype none
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata, // red_in, green_in, blue_in
	input wire logic s_tuser, // req_type
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata, // red_edge, green_edge, blue_edge
	output logic m_tlast, // run_last
	output logic m_tuser, // frame_last
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_data
);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_PRD, S_DRD, S_MAG, S_OUT} state_t;

	state_t state_q;
	logic [10:0] fw_q;
	logic [15:0] fh_q;
	logic [AW-1:0] col_q;
	logic [15:0] row_q;
	logic [WW-1:0] drn_q, dd_q;
	logic [1:0] dj_q;
	logic dv_q;
	logic [23:0] px_q;
	sem_pkg::sem_win_t win_q;
	logic rl_q, fl_q, pend2_q, start_q;
	logic [WW-1:0] w_eff;
	logic [15:0] h_eff;
	logic accept, is_drain, px_ok, dr_ok, lastc, h2;
	logic [AW-1:0] rd_addr;
	logic [47:0] rd_data;
	logic [WW:0] doff;
	logic dvalid;
	logic [23:0] top_v, mid_v;
	sem_pkg::sem_win_t base, sh1, sh2;
	sem_pkg::sem_nbr_t nbr [3];
	logic [2:0] done;
	logic [7:0] mag [3];

	function automatic sem_pkg::sem_win_t shift_col(sem_pkg::sem_win_t w, logic [23:0] t,
			logic [23:0] m, logic [23:0] b);
		sem_pkg::sem_win_t o;
		o = w;
		for (int r = 0; r < 3; r++) begin
			o[r*3] = w[r*3+1];
			o[r*3+1] = w[r*3+2];
		end
		o[2] = t;
		o[5] = m;
		o[8] = b;
		return o;
	endfunction

	assign w_eff = (fw_q == 11'd0) ? WW'(1) :
		({21'd0, fw_q} > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_q);
	assign h_eff = (fh_q == 16'd0) ? 16'd1 : fh_q;
	assign h2 = h_eff >= 16'd2;
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign is_drain = (s_tuser == sem_pkg::REQ_DRAIN);
	assign px_ok = (row_q < h_eff) && (WW'(col_q) < w_eff);
	assign dr_ok = (row_q >= h_eff) && (drn_q < w_eff);
	assign lastc = (WW'(col_q) == w_eff - WW'(1));
	assign doff = {1'b0, dd_q} + (WW+1)'(dj_q);
	assign dvalid = (doff != '0) && ((doff - (WW+1)'(1)) < {1'b0, w_eff});
	assign rd_addr = (state_q == S_DRD) ? AW'(doff - (WW+1)'(1)) : col_q;
	assign top_v = (row_q >= 16'd2) ? rd_data[47:24] : 24'd0;
	assign mid_v = (row_q != 16'd0) ? rd_data[23:0] : 24'd0;
	assign base = (col_q == '0) ? '0 : win_q;
	assign sh1 = shift_col(base, top_v, mid_v, px_q);
	assign sh2 = shift_col(sh1, 24'd0, 24'd0, 24'd0);

	sem_lbuf #(.DEPTH(MAX_WIDTH), .AW(AW)) u_lbuf (
		.clk(clk),
		.wr_en(state_q == S_PRD),
		.wr_addr(col_q),
		.wr_data({rd_data[23:0], px_q}),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	for (genvar k = 0; k < 3; k++) begin : g_ch
		for (genvar i = 0; i < 9; i++) begin : g_tap
			assign nbr[k][i] = win_q[i][23-8*k -: 8];
		end
		sem_mag u_mag (
			.clk(clk),
			.arst_n(arst_n),
			.start(start_q),
			.nbr(nbr[k]),
			.done(done[k]),
			.mag(mag[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fw_q <= sem_pkg::FW_RST;
			fh_q <= sem_pkg::FH_RST;
			col_q <= '0;
			row_q <= 16'd0;
			drn_q <= '0;
			dj_q <= 2'd0;
			dv_q <= 1'b0;
			rl_q <= 1'b0;
			fl_q <= 1'b0;
			pend2_q <= 1'b0;
			start_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == sem_pkg::CFG_FRAME_WIDTH) begin
					fw_q <= cfg_data[10:0];
				end else begin
					fh_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= 16'd0;
				drn_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && !is_drain && px_ok) begin
						state_q <= S_PRD;
					end else if (accept && is_drain && dr_ok) begin
						fl_q <= (drn_q == w_eff - WW'(1));
						rl_q <= 1'b1;
						pend2_q <= 1'b0;
						dj_q <= 2'd0;
						if (drn_q == w_eff - WW'(1)) begin
							col_q <= '0;
							row_q <= 16'd0;
							drn_q <= '0;
						end else begin
							drn_q <= drn_q + WW'(1);
						end
						state_q <= S_DRD;
					end
				end
				S_PRD: begin
					fl_q <= 1'b0;
					if (row_q != 16'd0 && col_q != '0) begin
						rl_q <= !lastc;
						pend2_q <= lastc;
						start_q <= 1'b1;
						state_q <= S_MAG;
					end else if (row_q != 16'd0 && lastc) begin
						rl_q <= 1'b1;
						pend2_q <= 1'b0;
						start_q <= 1'b1;
						state_q <= S_MAG;
					end else begin
						state_q <= S_IDLE;
					end
					if (lastc) begin
						col_q <= '0;
						row_q <= row_q + 16'd1;
					end else begin
						col_q <= col_q + AW'(1);
					end
				end
				S_DRD: begin
					dv_q <= dvalid;
					dj_q <= dj_q + 2'd1;
					if (dj_q == 2'd3) begin
						start_q <= 1'b1;
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					if (&done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						if (pend2_q) begin
							pend2_q <= 1'b0;
							rl_q <= 1'b1;
							start_q <= 1'b1;
							state_q <= S_MAG;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
			dd_q <= drn_q;
		end
		if (state_q == S_PRD) begin
			if (row_q == 16'd0 || col_q != '0 || !lastc) begin
				win_q <= sh1;
			end else begin
				win_q <= sh2;
			end
		end
		if (state_q == S_DRD && dj_q != 2'd0) begin
			win_q[4'(dj_q) - 4'd1] <= (dv_q && h2) ? rd_data[47:24] : 24'd0;
			win_q[4'(dj_q) + 4'd2] <= dv_q ? rd_data[23:0] : 24'd0;
			win_q[4'(dj_q) + 4'd5] <= 24'd0;
		end
		if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= {mag[2], mag[1], mag[0]};
			m_tlast <= rl_q;
			m_tuser <= fl_q;
			if (pend2_q) begin
				win_q <= shift_col(win_q, 24'd0, 24'd0, 24'd0);
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/sem_chk.sv
// Port-level assertions for the Sobel edge magnitude block, bound to the top level.
`default_nettype none
module sem_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic m_tlast,
	input wire logic m_tuser
);
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without run end");
	a_busy_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result loaded while idle");
endmodule

bind sobel_edge_magnitude_rgb sem_chk u_sem_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tlast(m_tlast),
	.m_tuser(m_tuser)
);
`default_nettype wire
